[rtl/core/fat16_cluster_chain_walker_assert.svh]
// Assertion macros for the FAT16 cluster chain walker
`ifndef FAT16_CLUSTER_CHAIN_WALKER_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_WALKER_ASSERT_SVH

// same-cycle implication, masked during reset
`define FCW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcw assertion failed");

// next-cycle implication, masked during reset
`define FCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcw assertion failed");

`endif

[rtl/core/fcw_pkg.sv]
// Shared types and constants for the FAT16 cluster chain walker
package fcw_pkg;

    localparam int FAT_ENTRIES_DEFAULT = 65536;

    localparam int CLUSTER_W = 16;
    localparam int ENTRY_W   = 16;
    localparam int SECTOR_W  = 32;
    localparam int SPC_W     = 8;
    localparam int CMD_W     = 2;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [ENTRY_W-1:0]   END_MARK_MIN       = 16'hFFF8;
    localparam logic [ENTRY_W-1:0]   NO_LINK            = 16'hFFFF;
    localparam logic [SECTOR_W-1:0]  FIRST_DATA_CLUSTER = 32'd2;
    // 32-byte entries, 512-byte sectors: 16 entries per sector
    localparam int                   ROOT_ENTRY_SHIFT   = 4;

    localparam logic [15:0] RESERVED_RESET = 16'd1;
    localparam logic [15:0] FAT_RESET      = 16'd1;
    localparam logic [15:0] ROOT_RESET     = 16'd512;
    localparam logic [7:0]  SPC_RESET      = 8'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_RESERVED = 2'd0,
        REG_FAT      = 2'd1,
        REG_ROOT     = 2'd2,
        REG_SPC      = 2'd3
    } reg_idx_t;

endpackage

[rtl/core/fcw_ifs.sv]
// Valid/ready channel interfaces for command and result words
interface fcw_in_if;
    import fcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [CLUSTER_W-1:0] cluster_index;
    logic [ENTRY_W-1:0]   entry_value;

    modport source (output valid, output cmd, output cluster_index, output entry_value,
                    input ready);
    modport sink   (input valid, input cmd, input cluster_index, input entry_value,
                    output ready);
endinterface

interface fcw_out_if;
    import fcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CLUSTER_W-1:0] cluster;
    logic [SECTOR_W-1:0]  sector_address;
    logic                 chain_end;

    modport source (output valid, output cluster, output sector_address, output chain_end,
                    input ready);
    modport sink   (input valid, input cluster, input sector_address, input chain_end,
                    output ready);
endinterface

[rtl/core/fcw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read
module fcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/core/fat16_cluster_chain_walker.sv]
// FAT16 cluster chain walker: table RAM, chain state and sector address output
//
//  channel   dir   handshake        word
//  in_ch     in    valid/ready      cmd, cluster_index, entry_value
//  out_ch    out   valid/ready      cluster, sector_address, chain_end
//  apb       in    psel/penable     4 config registers at 4*i, pready tied high
//
// Write entry and no-op go from idle to done; start and step that read the table
// pass through the read state, as the table RAM registers its read of the entry.
// One word is in flight at a time; the next is taken once the last result sits
// in the output register, so a stalled sink holds at most one word back.
// rst_n returns chain state and config to their reset values; table contents are undefined until written.
`include "fat16_cluster_chain_walker_assert.svh"

module fat16_cluster_chain_walker #(
    parameter int FAT_ENTRIES = fcw_pkg::FAT_ENTRIES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    fcw_in_if.sink                            in_ch,
    fcw_out_if.source                         out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fcw_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fcw_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [fcw_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import fcw_pkg::*;

    localparam int AW = $clog2(FAT_ENTRIES);
    localparam logic [CLUSTER_W:0] FAT_LIMIT = (CLUSTER_W+1)'(FAT_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] rsv_reg, fat_reg, root_reg;
    logic [7:0]  spc_reg;

    logic [CLUSTER_W-1:0] cur_reg, cur_next;
    logic [ENTRY_W-1:0]   link_reg, link_next;

    logic                 out_valid_reg, out_valid_next;
    logic [CLUSTER_W-1:0] out_cluster_reg;
    logic [SECTOR_W-1:0]  out_sector_reg;
    logic                 out_end_reg;

    logic                 accept;
    logic                 out_free;
    logic                 cfg_write;
    reg_idx_t             cfg_idx;
    logic                 idx_in_range;
    logic                 link_in_range;

    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [ENTRY_W-1:0]   mem_rdata;

    logic [17:0]          ds_sum;
    logic [SECTOR_W-1:0]  clu_off;
    logic [SECTOR_W-1:0]  sector_addr;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_RESERVED: prdata = CFG_DATA_W'(rsv_reg);
            REG_FAT:      prdata = CFG_DATA_W'(fat_reg);
            REG_ROOT:     prdata = CFG_DATA_W'(root_reg);
            REG_SPC:      prdata = CFG_DATA_W'(spc_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsv_reg  <= RESERVED_RESET;
            fat_reg  <= FAT_RESET;
            root_reg <= ROOT_RESET;
            spc_reg  <= SPC_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_RESERVED: rsv_reg  <= pwdata[15:0];
                REG_FAT:      fat_reg  <= pwdata[15:0];
                REG_ROOT:     root_reg <= pwdata[15:0];
                REG_SPC:      spc_reg  <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    // table RAM
    fcw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FAT_ENTRIES)
    ) u_fat_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (in_ch.cluster_index[AW-1:0]),
        .wdata (in_ch.entry_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ch.ready   = (state_reg == ST_IDLE);
    assign accept        = in_ch.valid && in_ch.ready;
    assign out_free      = !out_valid_reg || out_ch.ready;
    assign idx_in_range  = {1'b0, in_ch.cluster_index} < FAT_LIMIT;
    assign link_in_range = {1'b0, link_reg} < FAT_LIMIT;

    // first sector of the current cluster; data area origin wraps at 16 bits
    assign ds_sum      = 18'(rsv_reg) + 18'({fat_reg, 1'b0})
                       + 18'(root_reg >> ROOT_ENTRY_SHIFT);
    assign clu_off     = SECTOR_W'(cur_reg) - FIRST_DATA_CLUSTER;
    assign sector_addr = SECTOR_W'(ds_sum[15:0]) + clu_off * SECTOR_W'(spc_reg);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        link_next      = link_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = in_ch.cluster_index[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DONE;
                    unique case (cmd_t'(in_ch.cmd))
                        CMD_WRITE:
                        begin
                            if (idx_in_range)
                            begin
                                mem_we = 1'b1;
                                if (in_ch.cluster_index == cur_reg)
                                begin
                                    link_next = in_ch.entry_value;
                                end
                            end
                        end
                        CMD_START:
                        begin
                            cur_next = in_ch.cluster_index;
                            if (in_ch.cluster_index != '0 && idx_in_range)
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                link_next = NO_LINK;
                            end
                        end
                        CMD_STEP:
                        begin
                            // past the end the chain state stays put
                            if (link_reg < END_MARK_MIN)
                            begin
                                cur_next = link_reg;
                                if (link_in_range)
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = link_reg[AW-1:0];
                                    state_next = ST_READ;
                                end
                                else
                                begin
                                    link_next = NO_LINK;
                                end
                            end
                        end
                        CMD_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                link_next  = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            link_reg      <= NO_LINK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            link_reg      <= link_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_cluster_reg <= cur_reg;
            out_sector_reg  <= sector_addr;
            out_end_reg     <= (link_reg >= END_MARK_MIN);
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.cluster        = out_cluster_reg;
    assign out_ch.sector_address = out_sector_reg;
    assign out_ch.chain_end      = out_end_reg;

    `FCW_ASSERT_NEXT(a_read_then_done, clk, rst_n,
        state_reg == ST_READ, state_reg == ST_DONE)
    `FCW_ASSERT_NEXT(a_done_loads_result, clk, rst_n,
        state_reg == ST_DONE && !out_valid_reg, out_valid_reg && state_reg == ST_IDLE)
    `FCW_ASSERT_SAME(a_ram_single_access, clk, rst_n,
        mem_we, !mem_re && accept)
    `FCW_ASSERT_NEXT(a_chain_end_holds_on_step, clk, rst_n,
        accept && in_ch.cmd == CMD_STEP && link_reg >= END_MARK_MIN,
        $stable(cur_reg) && $stable(link_reg))
endmodule
